@@ rtl/tndq_pkg.sv @@
// Shared types, constants and codes for the transit node distance query block.
`timescale 1ns / 1ps

package tndq_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int TRANSIT_COUNT = 256;
    localparam int MAX_ACCESS    = 16;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int TR_W    = $clog2(TRANSIT_COUNT);
    localparam int ACC_W   = $clog2(MAX_ACCESS);
    localparam int CNT_W   = $clog2(MAX_ACCESS + 1);
    localparam int DIST_W  = 32;
    localparam int LIST_AW = NODE_W + ACC_W;
    localparam int TAB_AW  = 2 * TR_W;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [TR_W-1:0]    tr_t;
    typedef logic [ACC_W-1:0]   acc_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [LIST_AW-1:0] list_addr_t;
    typedef logic [TAB_AW-1:0]  tab_addr_t;

    localparam dist_t NO_PATH  = '1;
    localparam cnt_t  CNT_FULL = CNT_W'(MAX_ACCESS);

    typedef enum logic [2:0] {
        OP_MAP_WRITE   = 3'd0,
        OP_TABLE_WRITE = 3'd1,
        OP_ADD_FWD     = 3'd2,
        OP_ADD_BWD     = 3'd3,
        OP_QUERY       = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_WRITE_OK  = 2'd0,
        STAT_ANSWER    = 2'd1,
        STAT_LIST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_BLIST,
        S_BMAP,
        S_BSTORE,
        S_FLIST,
        S_FMAP,
        S_FGET,
        S_PAIR,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] opcode;
        node_t      first_node;
        node_t      second_node;
        tr_t        row_index;
        tr_t        col_index;
        dist_t      distance_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        dist_t      best_distance;
    } out_word_t;

    typedef struct packed {
        logic  mapped;
        tr_t   transit;
    } map_entry_t;

    typedef struct packed {
        node_t node;
        dist_t distance;
    } acc_entry_t;

    typedef struct packed {
        node_t      node_waddr;
        logic       map_we;
        map_entry_t map_wdata;
        node_t      map_raddr;
        logic       fcnt_we;
        logic       bcnt_we;
        cnt_t       cnt_wdata;
        node_t      fcnt_raddr;
        node_t      bcnt_raddr;
        list_addr_t list_waddr;
        logic       flist_we;
        logic       blist_we;
        acc_entry_t list_wdata;
        list_addr_t flist_raddr;
        list_addr_t blist_raddr;
        logic       tab_we;
        tab_addr_t  tab_waddr;
        dist_t      tab_wdata;
        tab_addr_t  tab_raddr;
    } store_req_t;

    typedef struct packed {
        map_entry_t map_rdata;
        cnt_t       fcnt_rdata;
        cnt_t       bcnt_rdata;
        acc_entry_t flist_rdata;
        acc_entry_t blist_rdata;
        dist_t      tab_rdata;
    } store_rsp_t;

endpackage

@@ rtl/tndq_store.sv @@
// Node map, list counts, access lists and transit distance table memories.
`timescale 1ns / 1ps

module tndq_store (
    input  logic                 aclk,
    input  tndq_pkg::store_req_t req,
    output tndq_pkg::store_rsp_t rsp
);
    import tndq_pkg::*;

    map_entry_t map_mem   [NODE_COUNT];
    cnt_t       fcnt_mem  [NODE_COUNT];
    cnt_t       bcnt_mem  [NODE_COUNT];
    acc_entry_t flist_mem [NODE_COUNT * MAX_ACCESS];
    acc_entry_t blist_mem [NODE_COUNT * MAX_ACCESS];
    dist_t      tab_mem   [TRANSIT_COUNT * TRANSIT_COUNT];

    map_entry_t map_rdata_reg;
    cnt_t       fcnt_rdata_reg;
    cnt_t       bcnt_rdata_reg;
    acc_entry_t flist_rdata_reg;
    acc_entry_t blist_rdata_reg;
    dist_t      tab_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.map_we) begin
            map_mem[req.node_waddr] <= req.map_wdata;
        end
        map_rdata_reg <= map_mem[req.map_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.fcnt_we) begin
            fcnt_mem[req.node_waddr] <= req.cnt_wdata;
        end
        fcnt_rdata_reg <= fcnt_mem[req.fcnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.bcnt_we) begin
            bcnt_mem[req.node_waddr] <= req.cnt_wdata;
        end
        bcnt_rdata_reg <= bcnt_mem[req.bcnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.flist_we) begin
            flist_mem[req.list_waddr] <= req.list_wdata;
        end
        flist_rdata_reg <= flist_mem[req.flist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.blist_we) begin
            blist_mem[req.list_waddr] <= req.list_wdata;
        end
        blist_rdata_reg <= blist_mem[req.blist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.tab_we) begin
            tab_mem[req.tab_waddr] <= req.tab_wdata;
        end
        tab_rdata_reg <= tab_mem[req.tab_raddr];
    end

    assign rsp.map_rdata   = map_rdata_reg;
    assign rsp.fcnt_rdata  = fcnt_rdata_reg;
    assign rsp.bcnt_rdata  = bcnt_rdata_reg;
    assign rsp.flist_rdata = flist_rdata_reg;
    assign rsp.blist_rdata = blist_rdata_reg;
    assign rsp.tab_rdata   = tab_rdata_reg;

endmodule

@@ rtl/tndq_min.sv @@
// Shared path-sum and running-minimum unit, one access pair per cycle.
`timescale 1ns / 1ps

module tndq_min (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clear,
    input  logic            issue,
    input  tndq_pkg::dist_t fdist,
    input  tndq_pkg::dist_t bdist,
    input  tndq_pkg::dist_t tdata,
    output tndq_pkg::dist_t best
);
    import tndq_pkg::*;

    logic  vld_reg;
    dist_t fb_reg;
    dist_t best_reg;
    dist_t sum;

    // Both access distances are summed while the table read is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            fb_reg <= fdist + bdist;
        end
    end

    assign sum = fb_reg + tdata;

    always_ff @(posedge aclk) begin
        if (clear) begin
            best_reg <= NO_PATH;
        end else if (vld_reg && tdata != NO_PATH && sum < best_reg) begin
            best_reg <= sum;
        end
    end

    assign best = best_reg;

endmodule

@@ rtl/transit_node_distance_query.sv @@
// Top level of the transit node distance query block: sequencer and handshakes.
//
// Input channel s_valid/s_ready/s_data carries one word per item: a map write,
// a table write, a forward or backward access append, or a query. Every item
// returns exactly one result word on m_valid/m_ready/m_data (status and
// best_distance), in order.
// A write or append passes through fetch, execute and finishing states; the
// block is ready again on the same edge that registers the result. A query
// caches each backward entry, then walks each forward entry against every
// cached one, then drains; with either list empty it goes straight to finish.
// The single table read port sets the pace: one access pair is read and
// folded into the minimum per cycle, and each access list entry needs a list
// read then a map read.
// Reset: aresetn is synchronous, active low. After release the block sweeps
// the node map and both list count memories to zero, one node per cycle,
// with s_ready low.
// Stall: the result sits in an output register, so the next item is taken
// while it waits; a finished item holds in its last state until that
// register is free.
`timescale 1ns / 1ps

module transit_node_distance_query (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tndq_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tndq_pkg::out_word_t m_data
);
    import tndq_pkg::*;

    localparam node_t CLR_LAST = NODE_W'(NODE_COUNT - 1);

    state_t     state_reg;
    state_t     state_next;
    node_t      clr_reg;
    in_word_t   item_reg;
    status_t    status_reg;
    cnt_t       nf_reg;
    cnt_t       nb_reg;
    acc_t       i_reg;
    acc_t       j_reg;
    tr_t        r_reg;
    dist_t      fdist_reg;
    dist_t      bd_reg [MAX_ACCESS];
    tr_t        bc_reg [MAX_ACCESS];
    logic       m_valid_reg;
    out_word_t  m_data_reg;

    store_req_t req;
    store_rsp_t rsp;
    logic       min_clear;
    logic       min_issue;
    dist_t      min_bdist;
    dist_t      best;
    logic       accept;
    logic       out_load;
    logic       i_last;
    logic       j_last;
    logic       fwd_full;
    logic       bwd_full;

    tndq_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    tndq_min u_min (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (min_clear),
        .issue   (min_issue),
        .fdist   (fdist_reg),
        .bdist   (min_bdist),
        .tdata   (rsp.tab_rdata),
        .best    (best)
    );

    assign accept   = s_valid && s_ready;
    assign i_last   = (CNT_W'(i_reg) + CNT_W'(1)) == nf_reg;
    assign j_last   = (CNT_W'(j_reg) + CNT_W'(1)) == nb_reg;
    assign fwd_full = rsp.fcnt_rdata >= CNT_FULL;
    assign bwd_full = rsp.bcnt_rdata >= CNT_FULL;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (opcode_t'(item_reg.opcode) == OP_QUERY && rsp.fcnt_rdata != '0
                        && rsp.bcnt_rdata != '0) begin
                    state_next = S_BLIST;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_BLIST: begin
                state_next = S_BMAP;
            end
            S_BMAP: begin
                state_next = S_BSTORE;
            end
            S_BSTORE: begin
                state_next = j_last ? S_FLIST : S_BLIST;
            end
            S_FLIST: begin
                state_next = S_FMAP;
            end
            S_FMAP: begin
                state_next = S_FGET;
            end
            S_FGET: begin
                state_next = S_PAIR;
            end
            S_PAIR: begin
                if (j_last) begin
                    state_next = i_last ? S_DRAIN : S_FLIST;
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory requests and strobes.
    always_comb begin
        req       = '0;
        min_clear = 1'b0;
        min_issue = 1'b0;
        min_bdist = bd_reg[j_reg];
        s_ready   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                req.node_waddr = clr_reg;
                req.map_we     = 1'b1;
                req.fcnt_we    = 1'b1;
                req.bcnt_we    = 1'b1;
            end
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_FETCH: begin
                req.map_raddr  = item_reg.first_node;
                req.fcnt_raddr = item_reg.first_node;
                req.bcnt_raddr = (opcode_t'(item_reg.opcode) == OP_QUERY)
                               ? item_reg.second_node : item_reg.first_node;
            end
            S_EXEC: begin
                min_clear               = 1'b1;
                req.node_waddr          = item_reg.first_node;
                req.map_wdata           = {1'b1, item_reg.row_index};
                req.tab_waddr           = {item_reg.row_index, item_reg.col_index};
                req.tab_wdata           = item_reg.distance_value;
                req.list_wdata.node     = item_reg.second_node;
                req.list_wdata.distance = item_reg.distance_value;
                case (opcode_t'(item_reg.opcode))
                    OP_MAP_WRITE: begin
                        req.map_we = !rsp.map_rdata.mapped;
                    end
                    OP_TABLE_WRITE: begin
                        req.tab_we = 1'b1;
                    end
                    OP_ADD_FWD: begin
                        req.fcnt_we    = !fwd_full;
                        req.flist_we   = !fwd_full;
                        req.cnt_wdata  = rsp.fcnt_rdata + CNT_W'(1);
                        req.list_waddr = {item_reg.first_node, rsp.fcnt_rdata[ACC_W-1:0]};
                    end
                    OP_ADD_BWD: begin
                        req.bcnt_we    = !bwd_full;
                        req.blist_we   = !bwd_full;
                        req.cnt_wdata  = rsp.bcnt_rdata + CNT_W'(1);
                        req.list_waddr = {item_reg.first_node, rsp.bcnt_rdata[ACC_W-1:0]};
                    end
                    default: begin
                    end
                endcase
            end
            S_BLIST: begin
                req.blist_raddr = {item_reg.second_node, j_reg};
            end
            S_BMAP: begin
                req.map_raddr = rsp.blist_rdata.node;
            end
            S_FLIST: begin
                req.flist_raddr = {item_reg.first_node, i_reg};
            end
            S_FMAP: begin
                req.map_raddr = rsp.flist_rdata.node;
            end
            S_PAIR: begin
                req.tab_raddr = {r_reg, bc_reg[j_reg]};
                min_issue     = 1'b1;
            end
            S_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + NODE_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: item, loop counters, backward list cache, result word.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        case (state_reg)
            S_EXEC: begin
                nf_reg <= rsp.fcnt_rdata;
                nb_reg <= rsp.bcnt_rdata;
                j_reg  <= '0;
                i_reg  <= '0;
                case (opcode_t'(item_reg.opcode))
                    OP_QUERY:   status_reg <= STAT_ANSWER;
                    OP_ADD_FWD: status_reg <= fwd_full ? STAT_LIST_FULL : STAT_WRITE_OK;
                    OP_ADD_BWD: status_reg <= bwd_full ? STAT_LIST_FULL : STAT_WRITE_OK;
                    default:    status_reg <= STAT_WRITE_OK;
                endcase
            end
            S_BMAP: begin
                bd_reg[j_reg] <= rsp.blist_rdata.distance;
            end
            S_BSTORE: begin
                bc_reg[j_reg] <= rsp.map_rdata.transit;
                if (!j_last) begin
                    j_reg <= j_reg + ACC_W'(1);
                end
            end
            S_FMAP: begin
                fdist_reg <= rsp.flist_rdata.distance;
            end
            S_FGET: begin
                r_reg <= rsp.map_rdata.transit;
                j_reg <= '0;
            end
            S_PAIR: begin
                if (!j_last) begin
                    j_reg <= j_reg + ACC_W'(1);
                end else if (!i_last) begin
                    i_reg <= i_reg + ACC_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_data_reg.status        <= status_reg;
            m_data_reg.best_distance <= (status_reg == STAT_ANSWER) ? best : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // A result word appears only out of the finishing state.
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word loaded outside the finishing state");

    // The pair loop never runs past the backward list length.
    a_pair_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PAIR |-> CNT_W'(j_reg) < nb_reg)
        else $error("pair index beyond backward list");

    // The forward walk never runs past the forward list length.
    a_fwd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FLIST |-> CNT_W'(i_reg) < nf_reg)
        else $error("forward index beyond forward list");

    // A forward append never writes into a full list.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.flist_we && state_reg == S_EXEC) |-> !fwd_full)
        else $error("forward append past list capacity");

    // Input is refused during the clearing sweep.
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == S_CLEAR) && state_reg == S_CLEAR |-> !s_ready)
        else $error("input accepted during clearing sweep");
`endif

endmodule

@@ test/transit_node_distance_query_test.sv @@
// Self-checking testbench for the transit node distance query block.
`timescale 1ns / 1ps

module transit_node_distance_query_test;
    import tndq_pkg::*;

    localparam int PERIOD       = 4;
    // The worst case is every item a full 16 x 16 query held up by stalls,
    // plus the clearing sweep; this limit is several times that.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_STEPS = 420;

    // Opcodes the block does not decode; it answers them like an ignored write.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef tab_addr_t slot_list_t[$];

    // Keeps a shadow copy of every store, predicts the answer word of each
    // accepted input word and checks result words in order.
    class distance_scoreboard;
        bit [TR_W-1:0]   transit_of  [NODE_COUNT];
        bit              is_mapped   [NODE_COUNT];
        bit [DIST_W-1:0] hop_table   [TRANSIT_COUNT*TRANSIT_COUNT];
        bit              hop_written [TRANSIT_COUNT*TRANSIT_COUNT];
        bit [NODE_W-1:0] fwd_node    [NODE_COUNT*MAX_ACCESS];
        bit [DIST_W-1:0] fwd_dist    [NODE_COUNT*MAX_ACCESS];
        bit [NODE_W-1:0] bwd_node    [NODE_COUNT*MAX_ACCESS];
        bit [DIST_W-1:0] bwd_dist    [NODE_COUNT*MAX_ACCESS];
        bit [CNT_W-1:0]  fwd_len     [NODE_COUNT];
        bit [CNT_W-1:0]  bwd_len     [NODE_COUNT];
        out_word_t       pending_answers[$];
        int              errors;

        // Least forward + hop + backward sum over all access pairs, mod 2^32,
        // skipping pairs whose hop is unreachable.
        function dist_t shortest_via_transit(node_t src, node_t dst);
            dist_t best;
            dist_t hop;
            dist_t total;
            tr_t   r;
            tr_t   c;
            best = NO_PATH;
            for (int i = 0; i < fwd_len[src]; i++) begin
                r = transit_of[fwd_node[{src, acc_t'(i)}]];
                for (int j = 0; j < bwd_len[dst]; j++) begin
                    c = transit_of[bwd_node[{dst, acc_t'(j)}]];
                    hop = hop_table[{r, c}];
                    total = fwd_dist[{src, acc_t'(i)}] + hop + bwd_dist[{dst, acc_t'(j)}];
                    if (hop != NO_PATH && total < best) best = total;
                end
            end
            return best;
        endfunction

        // Table slots a query would read that were never written.
        function slot_list_t list_unwritten(node_t src, node_t dst);
            slot_list_t slots;
            bit         seen[int];
            tab_addr_t  slot;
            for (int i = 0; i < fwd_len[src]; i++) begin
                for (int j = 0; j < bwd_len[dst]; j++) begin
                    slot = {transit_of[fwd_node[{src, acc_t'(i)}]],
                            transit_of[bwd_node[{dst, acc_t'(j)}]]};
                    if (!hop_written[slot] && !seen.exists(slot)) begin
                        seen[slot] = 1'b1;
                        slots.insert(slots.size(), slot);
                    end
                end
            end
            return slots;
        endfunction

        function void note_word(in_word_t w);
            out_word_t e;
            e = '0;
            case (w.opcode)
                OP_MAP_WRITE: begin
                    // first write to a node wins
                    if (!is_mapped[w.first_node]) begin
                        transit_of[w.first_node] = w.row_index;
                        is_mapped[w.first_node]  = 1'b1;
                    end
                end
                OP_TABLE_WRITE: begin
                    hop_table[{w.row_index, w.col_index}]   = w.distance_value;
                    hop_written[{w.row_index, w.col_index}] = 1'b1;
                end
                OP_ADD_FWD: begin
                    if (fwd_len[w.first_node] == MAX_ACCESS) begin
                        e.status = STAT_LIST_FULL;
                    end else begin
                        fwd_node[{w.first_node, acc_t'(fwd_len[w.first_node])}] = w.second_node;
                        fwd_dist[{w.first_node, acc_t'(fwd_len[w.first_node])}] =
                            w.distance_value;
                        fwd_len[w.first_node]++;
                    end
                end
                OP_ADD_BWD: begin
                    if (bwd_len[w.first_node] == MAX_ACCESS) begin
                        e.status = STAT_LIST_FULL;
                    end else begin
                        bwd_node[{w.first_node, acc_t'(bwd_len[w.first_node])}] = w.second_node;
                        bwd_dist[{w.first_node, acc_t'(bwd_len[w.first_node])}] =
                            w.distance_value;
                        bwd_len[w.first_node]++;
                    end
                end
                OP_QUERY: begin
                    e.status        = STAT_ANSWER;
                    e.best_distance = shortest_via_transit(w.first_node, w.second_node);
                end
                default: ;
            endcase
            pending_answers.insert(pending_answers.size(), e);
        endfunction

        function void check_word(out_word_t got);
            out_word_t e;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result word, actual status %0d best %0h",
                         $time, got.status, got.best_distance);
                errors++;
                return;
            end
            e = pending_answers.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, e.status, got.status);
                errors++;
            end
            if (got.best_distance !== e.best_distance) begin
                $display("%0t: best_distance mismatch, expected %0h actual %0h",
                         $time, e.best_distance, got.best_distance);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    distance_scoreboard board;
    int unsigned        cycle_count;
    // quiet: no idling on either side; hold_request: receiver holds off once
    bit                 quiet;
    bit                 hold_request;

    // Owners of access lists and access nodes come mostly from small pools so
    // that lists grow, fill up and share table slots; transit indices likewise.
    node_t owner_pool [12] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6,
                               10'd7, 10'd341, 10'd512, 10'd682, 10'd1023};
    node_t access_pool [24];
    tr_t   transit_pool [6] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd85, 8'd170};

    transit_node_distance_query dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #(PERIOD / 2) aclk = ~aclk;

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every result word taken at a clock edge; both sides are sampled
    // before this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_data);
    end

    // Receiver: stall at random, except in the quiet stretch; once asked,
    // hold off for a long stretch so the block backs up into its input.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    function automatic in_word_t pack_item(opcode_t op, node_t a, node_t b,
                                           tr_t row, tr_t col, dist_t d);
        in_word_t w;
        w.opcode         = op;
        w.first_node     = a;
        w.second_node    = b;
        w.row_index      = row;
        w.col_index      = col;
        w.distance_value = d;
        return w;
    endfunction

    // Bias distances toward the edges: unreachable, zero, tiny, near wrap.
    function automatic dist_t pick_distance();
        case ($urandom_range(0, 7))
            0:       return NO_PATH;
            1:       return '0;
            2:       return dist_t'($urandom_range(1, 64));
            3:       return NO_PATH - dist_t'($urandom_range(1, 64));
            default: return $urandom;
        endcase
    endfunction

    function automatic node_t pick_owner();
        if ($urandom_range(0, 99) < 85) return owner_pool[$urandom_range(0, 11)];
        return node_t'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic node_t pick_access();
        if ($urandom_range(0, 99) < 90) return access_pool[$urandom_range(0, 23)];
        return node_t'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic tr_t pick_transit();
        if ($urandom_range(0, 99) < 80) return transit_pool[$urandom_range(0, 5)];
        return tr_t'($urandom_range(0, TRANSIT_COUNT - 1));
    endfunction

    // Offer one word and hold it until taken. Drop valid only for an idle gap;
    // otherwise the next word replaces the last one in the same step.
    task automatic send_word(input in_word_t w);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
    endtask

    // Write every table slot the query would read that is still blank, with
    // random values, then issue the query itself.
    task automatic ask_distance(input node_t src, input node_t dst);
        slot_list_t slots;
        slots = board.list_unwritten(src, dst);
        foreach (slots[k]) begin
            send_word(pack_item(OP_TABLE_WRITE, node_t'($urandom), node_t'($urandom),
                                slots[k][TAB_AW-1:TR_W], slots[k][TR_W-1:0],
                                pick_distance()));
        end
        send_word(pack_item(OP_QUERY, src, dst, tr_t'($urandom), tr_t'($urandom),
                            $urandom));
    endtask

    // Pause the sender until every outstanding answer has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_answers.size() != 0);
    endtask

    initial begin
        in_word_t w;
        int       sel;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        board   = new();
        access_pool[0] = 10'd0;
        access_pool[1] = 10'd1023;
        access_pool[2] = 10'd7;
        access_pool[3] = 10'd9;
        for (int k = 4; k < 24; k++) access_pool[k] = node_t'($urandom_range(0, NODE_COUNT - 1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Query with both lists empty: no pair, unreachable.
        send_word(pack_item(OP_QUERY, 10'd0, 10'd1023, '0, '0, '0));
        // Map the top node to the top transit; a repeat map must not take.
        send_word(pack_item(OP_MAP_WRITE, 10'd1023, '0, 8'd255, '0, '0));
        send_word(pack_item(OP_MAP_WRITE, 10'd1023, '0, 8'd3, '0, '0));
        // Corner slots of the table: one unreachable, one near wrap.
        send_word(pack_item(OP_TABLE_WRITE, '0, '0, 8'd255, 8'd255, NO_PATH));
        send_word(pack_item(OP_TABLE_WRITE, '0, '0, 8'd255, 8'd0, 32'd10));
        send_word(pack_item(OP_TABLE_WRITE, '0, '0, 8'd0, 8'd255, 32'd0));
        send_word(pack_item(OP_TABLE_WRITE, '0, '0, 8'd0, 8'd0, 32'hFFFF_FFF0));
        // Nodes 7 and 9 stay unmapped and so read transit zero; the all-ones
        // access distance makes sums wrap.
        send_word(pack_item(OP_ADD_FWD, 10'd1, 10'd1023, '0, '0, NO_PATH));
        send_word(pack_item(OP_ADD_FWD, 10'd1, 10'd7, '0, '0, 32'd5));
        send_word(pack_item(OP_ADD_BWD, 10'd2, 10'd1023, '0, '0, 32'd1));
        send_word(pack_item(OP_ADD_BWD, 10'd2, 10'd9, '0, '0, 32'd32));
        ask_distance(10'd1, 10'd2);
        // Undecoded opcode with every other bit set.
        w = '1;
        w.opcode = OP_SPARE_HI;
        send_word(w);
        // Fill the backward list of node 2, then overflow it.
        for (int k = 0; k < MAX_ACCESS - 2; k++) begin
            send_word(pack_item(OP_ADD_BWD, 10'd2, (k % 2) ? 10'd1023 : 10'd0,
                                '0, '0, dist_t'(k * 1000)));
        end
        send_word(pack_item(OP_ADD_BWD, 10'd2, 10'd1023, '0, '0, 32'd77));
        drain_results();

        // Random part: mostly list building and queries over shared pools,
        // some stray opcodes as noise.
        for (int step = 0; step < RANDOM_STEPS; step++) begin
            if (step == 120) hold_request = 1'b1;
            if (step == 220) drain_results();
            quiet = (step >= 280 && step < 360);
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                send_word(pack_item(OP_MAP_WRITE, pick_access(), node_t'($urandom),
                                    pick_transit(), tr_t'($urandom), $urandom));
            end else if (sel < 20) begin
                send_word(pack_item(OP_TABLE_WRITE, node_t'($urandom), node_t'($urandom),
                                    pick_transit(), pick_transit(), pick_distance()));
            end else if (sel < 45) begin
                send_word(pack_item(OP_ADD_FWD, pick_owner(), pick_access(),
                                    tr_t'($urandom), tr_t'($urandom), pick_distance()));
            end else if (sel < 70) begin
                send_word(pack_item(OP_ADD_BWD, pick_owner(), pick_access(),
                                    tr_t'($urandom), tr_t'($urandom), pick_distance()));
            end else if (sel < 95) begin
                ask_distance(pick_owner(), pick_owner());
            end else begin
                w.opcode         = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                w.first_node     = node_t'($urandom);
                w.second_node    = node_t'($urandom);
                w.row_index      = tr_t'($urandom);
                w.col_index      = tr_t'($urandom);
                w.distance_value = $urandom;
                send_word(w);
            end
        end
        quiet = 1'b0;

        // Wait out the last answers, then a few more cycles for strays.
        drain_results();
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tndq_pkg.sv
rtl/tndq_store.sv
rtl/tndq_min.sv
rtl/transit_node_distance_query.sv
test/transit_node_distance_query_test.sv
